### src/fpr_pkg.sv
// Shared types, codes and mask functions for the fill pattern row generator.
// Used by fpr_row_gen, fill_pattern_row_generator_unit, fpr_checker and the testbench; depends on nothing.
package fpr_pkg;

    localparam int PATTERN_SIZE = 16;
    localparam int STYLE_W      = 8;
    localparam int KIND_W       = 3;
    localparam int ROW_IDX_W    = 4;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int USER_WORDS   = 4;

    localparam logic [KIND_W-1:0] KIND_PATTERN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_HATCH   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_USER    = 3'd4;

    localparam logic signed [STYLE_W-1:0] PAT_STYLES   = 8'sd24;
    localparam logic signed [STYLE_W-1:0] HATCH_STYLES = 8'sd12;
    localparam logic [4:0] DITHER_LAST = 5'd8;

    localparam logic [3:0] BAYER4 [0:3][0:3] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // How the row of one word is formed
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_DITHER,
        CLS_TEXTURE,
        CLS_HATCH,
        CLS_USER
    } fpr_class_t;

    typedef struct packed {
        fpr_class_t          cls;
        logic [3:0]          idx;   // dither level, texture or hatch number, from 0
        logic [ROW_IDX_W-1:0] row;
    } fpr_item_t;

    function automatic logic [2:0] dist4(input logic [2:0] v);
        logic [2:0] r;
        r = (v < 3'd4) ? 3'(3'd4 - v) : 3'(v - 3'd4);
        return r;
    endfunction

    function automatic logic [3:0] dist8(input logic [3:0] v);
        logic [3:0] r;
        r = (v < 4'd8) ? 4'(4'd8 - v) : 4'(v - 4'd8);
        return r;
    endfunction

    function automatic logic texture_pixel(input logic [3:0] t, input logic [3:0] x,
                                           input logic [3:0] y);
        logic [3:0] dxy;
        logic [4:0] dd8;
        logic [3:0] sum;
        logic [3:0] diff;
        logic [2:0] shx;
        logic       on;
        dxy  = 4'(dist4(x[2:0])) + 4'(dist4(y[2:0]));
        dd8  = 5'(dist8(x)) + 5'(dist8(y));
        sum  = x + y;
        diff = x - y;
        shx  = x[2:0] + (y[0] ? 3'd4 : 3'd0);
        unique case (t)
            4'd0:  on = (y[2:0] == 3'd0) || (x == (y[3] ? 4'd8 : 4'd0));
            4'd1:  on = (sum[2:0] == 3'd0);
            4'd2:  on = (x[2:0] == 3'd0) && (y[2:0] == 3'd0);
            4'd3:  on = (x[1:0] == 2'd0) || (y[1:0] == 2'd0);
            4'd4:  on = (sum[2:0] < 3'd2);
            4'd5:  on = (x[1:0] == 2'd1) && (y[1:0] == 2'd1);
            4'd6:  on = (x == 4'd0) && (y == 4'd0);
            4'd7:  on = (sum[1:0] == 2'd0);
            4'd8:  on = (dxy == 4'd3);
            4'd9:  on = (shx < 3'd2);
            4'd10: on = (diff[2:0] < 3'd2);
            4'd11: on = (x[2:0] < 3'd2) && (y[2:0] < 3'd2);
            4'd12: on = x[2] ^ y[2];
            4'd13: on = (dxy < 4'd3);
            4'd14: on = (dd8 < 5'd6);
            default: on = (diff[1:0] < 2'd2);
        endcase
        return on;
    endfunction

    function automatic logic hatch_pixel(input logic [3:0] h, input logic [3:0] x,
                                         input logic [3:0] y);
        logic [3:0] sum;
        logic [3:0] diff;
        logic       on;
        sum  = x + y;
        diff = x - y;
        unique case (h)
            4'd0:  on = (diff[1:0] == 2'd0);
            4'd1:  on = (sum[1:0] == 2'd0);
            4'd2:  on = (diff[1:0] == 2'd0) || (sum[1:0] == 2'd0);
            4'd3:  on = (x[1:0] == 2'd0);
            4'd4:  on = (y[1:0] == 2'd0);
            4'd5:  on = (x[1:0] == 2'd0) || (y[1:0] == 2'd0);
            4'd6:  on = (diff[2:0] < 3'd2);
            4'd7:  on = (sum[2:0] < 3'd2);
            4'd8:  on = (diff[2:0] < 3'd2) || (sum[2:0] < 3'd2);
            4'd9:  on = (x[2:0] < 3'd2);
            4'd10: on = (y[2:0] < 3'd2);
            default: on = (x[2:0] < 3'd2) || (y[2:0] < 3'd2);
        endcase
        return on;
    endfunction

endpackage

### src/fpr_row_gen.sv
// Row builder: forms the 16 mask bits of one decoded word, one pixel lane per bit.
// Depends on fpr_pkg (item type, class codes, Bayer table, pixel functions).
module fpr_row_gen (
    input  fpr_pkg::fpr_item_t                                  item,
    input  logic [fpr_pkg::USER_WORDS-1:0][fpr_pkg::CFG_W-1:0] user_rows,
    output logic [fpr_pkg::PATTERN_SIZE-1:0]                    row_bits,
    output logic                                                has_pattern
);

    logic [fpr_pkg::PATTERN_SIZE-1:0] dither_row;
    logic [fpr_pkg::PATTERN_SIZE-1:0] texture_row;
    logic [fpr_pkg::PATTERN_SIZE-1:0] hatch_row;
    logic [fpr_pkg::PATTERN_SIZE-1:0] user_row;
    logic [4:0]                       thr;
    logic [fpr_pkg::CFG_W-1:0]        user_word;

    // Threshold is twice the style number; idx holds style minus one
    assign thr = {item.idx + 4'd1, 1'b0};

    for (genvar gx = 0; gx < fpr_pkg::PATTERN_SIZE; gx++) begin : g_px
        localparam logic [3:0] XC = 4'(gx);
        assign dither_row[gx]  = 5'(fpr_pkg::BAYER4[item.row[1:0]][XC[1:0]]) < thr;
        assign texture_row[gx] = fpr_pkg::texture_pixel(item.idx, XC, item.row);
        assign hatch_row[gx]   = fpr_pkg::hatch_pixel(item.idx, XC, item.row);
    end

    assign user_word = user_rows[item.row[3:2]];
    assign user_row  = user_word[{item.row[1:0], 4'd0} +: fpr_pkg::PATTERN_SIZE];

    always_comb
    begin
        has_pattern = 1'b1;
        unique case (item.cls)
            fpr_pkg::CLS_DITHER:  row_bits = dither_row;
            fpr_pkg::CLS_TEXTURE: row_bits = texture_row;
            fpr_pkg::CLS_HATCH:   row_bits = hatch_row;
            fpr_pkg::CLS_USER:    row_bits = user_row;
            default:
            begin
                row_bits    = '0;
                has_pattern = 1'b0;
            end
        endcase
    end

endmodule

### src/fill_pattern_row_generator_unit.sv
// Top level of the fill pattern row generator: three-stage pipeline and user pattern words.
// Depends on fpr_pkg and fpr_row_gen.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle while ready: interior_kind,
//   style_number (signed) and row_index. Output channel (out_valid/out_ready)
//   returns one word for each input word, in order: row_bits and has_pattern.
//   Kind 2 gives a dither level (styles 1..8) or a texture (9..24), kind 3 a
//   hatch (1..12), kind 4 the user row; styles outside the range clamp to the
//   end styles. Other kinds give has_pattern low and a zero row.
//   Config port: cfg_we writes cfg_data into user word cfg_index at the clock
//   edge; write only while no word is in flight.
// Timing:
//   Stage 1 registers the input word, stage 2 holds the clamped, decoded style,
//   stage 3 is the output register with the finished row. out_valid rises once
//   the word has moved from stage 1 through stage 2 into stage 3; throughput is
//   one word per cycle while the receiver keeps out_ready high.
// Reset and stalls:
//   rst_n clears all stage valid bits and the user words to zero. When the
//   receiver holds out_ready low, each stage fills in turn and in_ready drops
//   only once every stage holds a word; nothing is dropped or repeated.
module fill_pattern_row_generator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fpr_pkg::KIND_W-1:0]          interior_kind,
    input  logic signed [fpr_pkg::STYLE_W-1:0]  style_number,
    input  logic [fpr_pkg::ROW_IDX_W-1:0]       row_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fpr_pkg::PATTERN_SIZE-1:0]    row_bits,
    output logic                                has_pattern,
    input  logic                                cfg_we,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpr_pkg::CFG_W-1:0]           cfg_data
);

    // User pattern words
    logic [fpr_pkg::USER_WORDS-1:0][fpr_pkg::CFG_W-1:0] user_rows_reg;

    // Stage 1: raw input word
    logic                                v1_reg, v1_next;
    logic [fpr_pkg::KIND_W-1:0]          kind1_reg;
    logic signed [fpr_pkg::STYLE_W-1:0]  style1_reg;
    logic [fpr_pkg::ROW_IDX_W-1:0]       row1_reg;

    // Stage 2: decoded word
    logic                                v2_reg, v2_next;
    fpr_pkg::fpr_item_t                  item2_reg, item2_next;

    // Stage 3: output register
    logic                                v3_reg, v3_next;
    logic [fpr_pkg::PATTERN_SIZE-1:0]    row3_reg, row3_next;
    logic                                has3_reg, has3_next;

    logic ready1, ready2, ready3;
    logic [4:0] pat_style;
    logic [3:0] hatch_style;

    // A stage takes a new word when it is empty or its word moves on
    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign v1_next = ready1 ? in_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg   : v2_reg;
    assign v3_next = ready3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            user_rows_reg <= '0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (cfg_we)
                user_rows_reg[cfg_index] <= cfg_data;
        end
    end

    // Clamp the style and pick the row class
    always_comb
    begin
        if (style1_reg < 8'sd1)
            pat_style = 5'd1;
        else if (style1_reg > fpr_pkg::PAT_STYLES)
            pat_style = 5'(fpr_pkg::PAT_STYLES);
        else
            pat_style = style1_reg[4:0];

        if (style1_reg < 8'sd1)
            hatch_style = 4'd1;
        else if (style1_reg > fpr_pkg::HATCH_STYLES)
            hatch_style = 4'(fpr_pkg::HATCH_STYLES);
        else
            hatch_style = style1_reg[3:0];

        item2_next.row = row1_reg;
        item2_next.idx = 4'd0;
        item2_next.cls = fpr_pkg::CLS_NONE;
        priority if (kind1_reg == fpr_pkg::KIND_PATTERN)
        begin
            if (pat_style <= fpr_pkg::DITHER_LAST)
            begin
                item2_next.cls = fpr_pkg::CLS_DITHER;
                item2_next.idx = 4'(pat_style - 5'd1);
            end
            else
            begin
                item2_next.cls = fpr_pkg::CLS_TEXTURE;
                item2_next.idx = 4'(pat_style - 5'd9);
            end
        end
        else if (kind1_reg == fpr_pkg::KIND_HATCH)
        begin
            item2_next.cls = fpr_pkg::CLS_HATCH;
            item2_next.idx = hatch_style - 4'd1;
        end
        else if (kind1_reg == fpr_pkg::KIND_USER)
            item2_next.cls = fpr_pkg::CLS_USER;
        else
            item2_next.cls = fpr_pkg::CLS_NONE;
    end

    fpr_row_gen u_row_gen (
        .item        (item2_reg),
        .user_rows   (user_rows_reg),
        .row_bits    (row3_next),
        .has_pattern (has3_next)
    );

    // Payload registers: load when the stage advances, hold otherwise
    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            kind1_reg  <= interior_kind;
            style1_reg <= style_number;
            row1_reg   <= row_index;
        end
        if (ready2 && v1_reg)
            item2_reg <= item2_next;
        if (ready3 && v2_reg)
        begin
            row3_reg <= row3_next;
            has3_reg <= has3_next;
        end
    end

    assign out_valid   = v3_reg;
    assign row_bits    = row3_reg;
    assign has_pattern = has3_reg;

endmodule

### src/fpr_checker.sv
// Port-level checks for fill_pattern_row_generator_unit, attached by bind.
// Depends on fpr_pkg for port widths.
module fpr_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [fpr_pkg::PATTERN_SIZE-1:0]    row_bits,
    input logic                                has_pattern
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_bits) && $stable(has_pattern))
        else $error("output word changed while stalled");

    // Words without a pattern (solid, hollow or other kinds) give an empty row
    a_no_pattern_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_pattern |-> row_bits == '0)
        else $error("row bits set without a pattern");

    // With the output register empty the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // A word taken while the output register is empty reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##3 out_valid)
        else $error("word did not reach the output");

endmodule

bind fill_pattern_row_generator_unit fpr_checker u_fpr_checker (.*);

### verif/tb_fill_pattern_row_generator_unit.sv
// Testbench for fill_pattern_row_generator_unit: directed and random mask row lookups,
// checked word by word against an in-bench row predictor held in a small scoreboard.
// Depends on fpr_pkg and the RTL of the unit; needs no files or arguments.
module tb_fill_pattern_row_generator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: keeps its own copy of the four user pattern words, predicts the
    // mask row of every accepted request and checks results in order.
    class mask_row_board;
        logic [63:0] user_words [4];
        logic [15:0] rows_owed [$];
        logic        flags_owed [$];
        int          errors;

        function new();
            for (int i = 0; i < 4; i++)
            begin
                user_words[i] = '0;
            end
            errors = 0;
        endfunction

        function void set_user_word(int idx, logic [63:0] value);
            user_words[idx] = value;
        endfunction

        function int pending();
            return rows_owed.size();
        endfunction

        function int gap(int a, int b);
            return (a < b) ? b - a : a - b;
        endfunction

        function int clamp_style(int s, int hi);
            if (s < 1)
                return 1;
            if (s > hi)
                return hi;
            return s;
        endfunction

        // Texture number t (0..15) is pattern style 9 + t
        function bit texture_on(int t, int x, int y);
            int dx;
            int dy;
            int sum;
            int diff;
            dx   = gap(x & 7, 4);
            dy   = gap(y & 7, 4);
            sum  = x + y;
            diff = (x - y) & 15;
            case (t)
                0:  return ((y & 7) == 0) || (x == (((y >> 3) & 1) != 0 ? 8 : 0));
                1:  return (sum & 7) == 0;
                2:  return ((x & 7) == 0) && ((y & 7) == 0);
                3:  return ((x & 3) == 0) || ((y & 3) == 0);
                4:  return (sum & 7) < 2;
                5:  return ((x & 3) == 1) && ((y & 3) == 1);
                6:  return (x == 0) && (y == 0);
                7:  return (sum & 3) == 0;
                8:  return (dx + dy) == 3;
                9:  return ((x + ((y & 1) != 0 ? 4 : 0)) & 7) < 2;
                10: return (diff & 7) < 2;
                11: return ((x & 7) < 2) && ((y & 7) < 2);
                12: return (((x >> 2) ^ (y >> 2)) & 1) != 0;
                13: return (dx + dy) < 3;
                14: return (gap(x, 8) + gap(y, 8)) < 6;
                default: return (diff & 3) < 2;
            endcase
        endfunction

        // Hatch number h (0..11) is hatch style 1 + h
        function bit hatch_on(int h, int x, int y);
            int sum;
            int diff;
            sum  = x + y;
            diff = (x - y) & 15;
            case (h)
                0:  return (diff & 3) == 0;
                1:  return (sum & 3) == 0;
                2:  return ((diff & 3) == 0) || ((sum & 3) == 0);
                3:  return (x & 3) == 0;
                4:  return (y & 3) == 0;
                5:  return ((x & 3) == 0) || ((y & 3) == 0);
                6:  return (diff & 7) < 2;
                7:  return (sum & 7) < 2;
                8:  return ((diff & 7) < 2) || ((sum & 7) < 2);
                9:  return (x & 7) < 2;
                10: return (y & 7) < 2;
                default: return ((x & 7) < 2) || ((y & 7) < 2);
            endcase
        endfunction

        function void note_request(logic [2:0] kind, logic signed [7:0] style,
                                   logic [3:0] row);
            logic [3:0]  rank [4][4] = '{'{0, 8, 2, 10}, '{12, 4, 14, 6},
                                         '{3, 11, 1, 9}, '{15, 7, 13, 5}};
            int          s;
            int          y;
            logic [15:0] bits;
            logic        has;
            s    = style;
            y    = row;
            bits = '0;
            has  = 1'b1;
            if (kind == fpr_pkg::KIND_PATTERN)
            begin
                s = clamp_style(s, int'(fpr_pkg::PAT_STYLES));
                for (int x = 0; x < fpr_pkg::PATTERN_SIZE; x++)
                begin
                    if (s <= 8)
                        bits[x] = int'(rank[y & 3][x & 3]) < 2 * s;
                    else
                        bits[x] = texture_on(s - 9, x, y);
                end
            end
            else if (kind == fpr_pkg::KIND_HATCH)
            begin
                s = clamp_style(s, int'(fpr_pkg::HATCH_STYLES));
                for (int x = 0; x < fpr_pkg::PATTERN_SIZE; x++)
                begin
                    bits[x] = hatch_on(s - 1, x, y);
                end
            end
            else if (kind == fpr_pkg::KIND_USER)
            begin
                bits = user_words[y >> 2][(y & 3) * 16 +: 16];
            end
            else
            begin
                has = 1'b0;
            end
            rows_owed.push_back(bits);
            flags_owed.push_back(has);
        endfunction

        function void check_row(logic [15:0] bits, logic has);
            logic [15:0] want_bits;
            logic        want_has;
            if (rows_owed.size() == 0)
            begin
                $error("row_bits: no word expected, actual %h", bits);
                errors++;
                return;
            end
            want_bits = rows_owed.pop_front();
            want_has  = flags_owed.pop_front();
            if (bits !== want_bits)
            begin
                $error("row_bits mismatch: expected %h, actual %h", want_bits, bits);
                errors++;
            end
            if (has !== want_has)
            begin
                $error("has_pattern mismatch: expected %b, actual %b", want_has, has);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  interior_kind = '0;
    logic signed [7:0] style_number = '0;
    logic [3:0]  row_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] row_bits;
    logic        has_pattern;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Percent of cycles the sender idles and the receiver stalls
    int send_idle = 0;
    int recv_stall = 0;

    mask_row_board board = new();

    fill_pattern_row_generator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .interior_kind (interior_kind),
        .style_number  (style_number),
        .row_index     (row_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_bits      (row_bits),
        .has_pattern   (has_pattern),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (about 2000 words, worst idling)
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: check each word taken at an edge, then pick the next ready level.
    // Values read right after the edge are the ones the DUT saw at that edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_row(row_bits, has_pattern);
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Offer one request word; idle first at random, then hold valid and payload
    // until the DUT takes it. Returns at the edge of acceptance with valid high.
    task automatic send_request(input logic [2:0] kind, input logic signed [7:0] style,
                                input logic [3:0] row);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        interior_kind <= kind;
        style_number  <= style;
        row_index     <= row;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(kind, style, row);
    endtask

    // Drop valid and wait until every owed row has come back and a further edge
    // so that the config port only moves with the pipeline empty.
    task automatic drain_rows();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        @(posedge clk);
    endtask

    // Write all four user pattern words on consecutive edges
    task automatic load_user_pattern(input logic [63:0] w0, input logic [63:0] w1,
                                     input logic [63:0] w2, input logic [63:0] w3);
        logic [63:0] words [4];
        words = '{w0, w1, w2, w3};
        for (int i = 0; i < fpr_pkg::USER_WORDS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= words[i];
            board.set_user_word(i, words[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly legal styles with random content, some anywhere in the signed range
    task automatic send_random_request();
        logic [2:0]        kind;
        logic signed [7:0] style;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40)
            kind = fpr_pkg::KIND_PATTERN;
        else if (pick < 65)
            kind = fpr_pkg::KIND_HATCH;
        else if (pick < 85)
            kind = fpr_pkg::KIND_USER;
        else
        begin
            // solid, hollow or unused kinds
            do
                kind = 3'($urandom_range(7));
            while (kind == fpr_pkg::KIND_PATTERN || kind == fpr_pkg::KIND_HATCH ||
                   kind == fpr_pkg::KIND_USER);
        end
        if ($urandom_range(3) == 0)
            style = 8'($urandom_range(255));
        else if (kind == fpr_pkg::KIND_HATCH)
            style = 8'($urandom_range(int'(fpr_pkg::HATCH_STYLES), 1));
        else
            style = 8'($urandom_range(int'(fpr_pkg::PAT_STYLES), 1));
        send_request(kind, style, 4'($urandom_range(15)));
    endtask

    initial
    begin
        int stall_plan [4][2] = '{'{0, 0}, '{84, 0}, '{0, 84}, '{37, 37}};

        // Hold reset low from time zero, release at an edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every kind once, then style extremes and clamp edges.
        // User rows here read the reset value of the pattern words.
        for (int k = 0; k < 8; k++)
        begin
            send_request(3'(k), 8'sd1, 4'd3);
        end
        send_request(fpr_pkg::KIND_PATTERN, -8'sd128, 4'd0);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd0, 4'd15);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd8, 4'd5);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd9, 4'd7);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd24, 4'd10);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd25, 4'd15);
        send_request(fpr_pkg::KIND_PATTERN, 8'sd127, 4'd0);
        send_request(fpr_pkg::KIND_HATCH, -8'sd1, 4'd15);
        send_request(fpr_pkg::KIND_HATCH, 8'sd6, 4'd2);
        send_request(fpr_pkg::KIND_HATCH, 8'sd7, 4'd9);
        send_request(fpr_pkg::KIND_HATCH, 8'sd12, 4'd0);
        send_request(fpr_pkg::KIND_HATCH, 8'sd13, 4'd15);
        send_request(fpr_pkg::KIND_HATCH, 8'sd127, 4'd4);
        send_request(fpr_pkg::KIND_USER, 8'sd0, 4'd0);
        send_request(fpr_pkg::KIND_USER, -8'sd1, 4'd15);

        // Random phases, each with its own idling mix and user pattern.
        // Halfway through each phase, stop sending until the pipe is empty
        // and swap in a random pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_rows();
            send_idle  = stall_plan[phase][0];
            recv_stall = stall_plan[phase][1];
            case (phase)
                0: load_user_pattern('1, '1, '1, '1);
                1: load_user_pattern({4{16'hAAAA}}, {4{16'h5555}},
                                     {4{16'h5555}}, {4{16'hAAAA}});
                default: load_user_pattern(random_word(), random_word(),
                                           random_word(), random_word());
            endcase
            for (int i = 0; i < 500; i++)
            begin
                if (i == 250)
                begin
                    drain_rows();
                    load_user_pattern(random_word(), random_word(),
                                      random_word(), random_word());
                end
                send_random_request();
            end
        end

        // Wait out the last rows, then keep the clock running to catch stray words
        drain_rows();
        repeat (8) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
src/fpr_pkg.sv
src/fpr_row_gen.sv
src/fill_pattern_row_generator_unit.sv
src/fpr_checker.sv
verif/tb_fill_pattern_row_generator_unit.sv
